// ===== rtl/core/lci_pkg.sv =====
// Shared types and constants of the line and circle intersection core.
package lci_pkg;

   // Control word that travels with each request down the pipeline.
   typedef struct packed {
      logic valid;
      logic hit;
   } ctl_type;

   // Operand slice width of the pipelined multipliers.
   localparam int unsigned MUL_CHUNK = 32;

endpackage

// ===== rtl/core/lci_mul.sv =====
// Two stage unsigned multiplier built from 32 by 32 bit partial products.
module lci_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic               clock,
   input  logic [AW-1:0]      a,
   input  logic [BW-1:0]      b,
   output logic [AW+BW-1:0]   p
);
   import lci_pkg::*;

   localparam int CW = MUL_CHUNK;
   localparam int NA = (AW + CW - 1) / CW;
   localparam int NB = (BW + CW - 1) / CW;
   localparam int PW = (NA + NB) * CW;

   logic [NA*CW-1:0] a_pad;
   logic [NB*CW-1:0] b_pad;
   logic [2*CW-1:0]  pp_ff [NA*NB];
   logic [PW-1:0]    sum_in;
   logic [AW+BW-1:0] p_ff;

   assign a_pad = (NA*CW)'(a);
   assign b_pad = (NB*CW)'(b);

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (PW'(pp_ff[i*NB+j]) << ((i + j) * CW));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_ff[i*NB+j] <= (2*CW)'(a_pad[i*CW +: CW]) * (2*CW)'(b_pad[j*CW +: CW]);
         end
      end
      p_ff <= sum_in[AW+BW-1:0];
   end

   assign p = p_ff;

endmodule

// ===== rtl/core/lci_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, with side data.
module lci_sqrt #(
   parameter int NW = 128,
   parameter int SW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  lci_pkg::ctl_type    in_ctl,
   input  logic [NW-1:0]       in_value,
   input  logic [SW-1:0]       in_side,
   output lci_pkg::ctl_type    out_ctl,
   output logic [NW/2-1:0]     out_root,
   output logic [SW-1:0]       out_side
);
   import lci_pkg::*;

   localparam int H  = NW / 2;
   localparam int RW = H + 2;

   ctl_type       ctl_ff  [H];
   ctl_type       ctl_in  [H];
   logic [RW-1:0] rem_ff  [H];
   logic [RW-1:0] rem_in  [H];
   logic [H-1:0]  root_ff [H];
   logic [H-1:0]  root_in [H];
   logic [NW-1:0] val_ff  [H];
   logic [NW-1:0] val_in  [H];
   logic [SW-1:0] side_ff [H];
   logic [SW-1:0] side_in [H];

   always_comb begin
      logic [RW-1:0] prem;
      logic [RW-1:0] rsh;
      logic [RW-1:0] trial;
      logic [H-1:0]  proot;
      logic [NW-1:0] pval;
      int            j;
      for (int k = 0; k < H; k++) begin
         j = (k == 0) ? 0 : k - 1;
         if (k == 0) begin
            prem       = '0;
            proot      = '0;
            pval       = in_value;
            ctl_in[k]  = in_ctl;
            side_in[k] = in_side;
         end else begin
            prem       = rem_ff[j];
            proot      = root_ff[j];
            pval       = val_ff[j];
            ctl_in[k]  = ctl_ff[j];
            side_in[k] = side_ff[j];
         end
         // bring down the next two radicand bits and try a one
         rsh   = {prem[RW-3:0], pval[NW-1:NW-2]};
         trial = {proot, 2'b01};
         if (rsh >= trial) begin
            rem_in[k]  = rsh - trial;
            root_in[k] = {proot[H-2:0], 1'b1};
         end else begin
            rem_in[k]  = rsh;
            root_in[k] = {proot[H-2:0], 1'b0};
         end
         val_in[k] = {pval[NW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < H; k++) ctl_ff[k] <= '0;
      end else begin
         for (int k = 0; k < H; k++) ctl_ff[k] <= ctl_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < H; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         val_ff[k]  <= val_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_ctl  = ctl_ff[H-1];
   assign out_root = root_ff[H-1];
   assign out_side = side_ff[H-1];

endmodule

// ===== rtl/core/lci_div.sv =====
// Pipelined restoring divider for several signed numerators over one divisor.
module lci_div #(
   parameter int NW    = 98,
   parameter int DW    = 65,
   parameter int QW    = 32,
   parameter int LANES = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lci_pkg::ctl_type             in_ctl,
   input  logic [LANES-1:0][NW-1:0]     in_num,
   input  logic [DW-1:0]                in_den,
   output lci_pkg::ctl_type             out_ctl,
   output logic [LANES-1:0][QW-1:0]     out_quot,
   output logic [LANES-1:0]             out_neg,
   output logic [LANES-1:0]             out_ovf
);
   import lci_pkg::*;

   localparam int MX = (NW > DW + QW) ? NW : DW + QW;
   localparam int NS = QW + 1;

   ctl_type                   ctl_ff  [NS];
   ctl_type                   ctl_in  [NS];
   logic [LANES-1:0][MX-1:0]  rem_ff  [NS];
   logic [LANES-1:0][MX-1:0]  rem_in  [NS];
   logic [LANES-1:0][QW-1:0]  quot_ff [NS];
   logic [LANES-1:0][QW-1:0]  quot_in [NS];
   logic [DW-1:0]             den_ff  [NS];
   logic [DW-1:0]             den_in  [NS];
   logic [LANES-1:0]          neg_ff  [NS];
   logic [LANES-1:0]          neg_in  [NS];
   logic [LANES-1:0]          ovf_ff  [NS];
   logic [LANES-1:0]          ovf_in  [NS];

   always_comb begin
      logic [NW-1:0] mag;
      logic [MX-1:0] dsh;
      int            j;
      for (int k = 0; k < NS; k++) begin
         j = (k == 0) ? 0 : k - 1;
         if (k == 0) begin
            // take magnitudes and flag quotients too wide for the result
            ctl_in[k] = in_ctl;
            den_in[k] = in_den;
            dsh       = MX'(in_den) << QW;
            for (int l = 0; l < LANES; l++) begin
               mag           = in_num[l][NW-1] ? (~in_num[l] + 1'b1) : in_num[l];
               neg_in[k][l]  = in_num[l][NW-1];
               rem_in[k][l]  = MX'(mag);
               ovf_in[k][l]  = MX'(mag) >= dsh;
               quot_in[k][l] = '0;
            end
         end else begin
            ctl_in[k] = ctl_ff[j];
            den_in[k] = den_ff[j];
            neg_in[k] = neg_ff[j];
            ovf_in[k] = ovf_ff[j];
            dsh       = MX'(den_ff[j]) << (QW - k);
            for (int l = 0; l < LANES; l++) begin
               if (rem_ff[j][l] >= dsh) begin
                  rem_in[k][l]  = rem_ff[j][l] - dsh;
                  quot_in[k][l] = quot_ff[j][l] | (QW'(1) << (QW - k));
               end else begin
                  rem_in[k][l]  = rem_ff[j][l];
                  quot_in[k][l] = quot_ff[j][l];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) ctl_ff[k] <= '0;
      end else begin
         for (int k = 0; k < NS; k++) ctl_ff[k] <= ctl_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         rem_ff[k]  <= rem_in[k];
         quot_ff[k] <= quot_in[k];
         den_ff[k]  <= den_in[k];
         neg_ff[k]  <= neg_in[k];
         ovf_ff[k]  <= ovf_in[k];
      end
   end

   assign out_ctl  = ctl_ff[NS-1];
   assign out_quot = quot_ff[NS-1];
   assign out_neg  = neg_ff[NS-1];
   assign out_ovf  = ovf_ff[NS-1];

endmodule

// ===== rtl/core/line_circle_intersection.sv =====
// Line and circle intersection core: fully pipelined, one request per cycle.
// The square root yields one root bit per stage, the divider one quotient bit per stage after its input stage.
// Throughput is one request per clock; busy is never raised and results cannot be stalled.
// Synchronous active high reset clears every valid bit; data registers are not reset.
module line_circle_intersection #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic        [COORD_WIDTH-2:0] req_radius,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_first_x,
   output logic signed [COORD_WIDTH-1:0] rsp_first_y,
   output logic signed [COORD_WIDTH-1:0] rsp_second_x,
   output logic signed [COORD_WIDTH-1:0] rsp_second_y
);
   import lci_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int DRW  = 2 * W + 1;   // dx*dx + dy*dy, unsigned
   localparam int CRW  = 2 * W + 1;   // cross product D, signed
   localparam int DETW = 4 * W + 1;   // r*r*dr - D*D, signed
   localparam int SQW  = 2 * W;       // floor square root of det
   localparam int NUMW = 3 * W + 2;   // quotient numerators, signed

   // Side data carried alongside the multipliers and the square root.
   typedef struct packed {
      logic         sp1;
      logic         sp2;
      logic         sdx;
      logic         sdy;
      logic [W-1:0] adx;
      logic [W-1:0] ady;
   } pa_type;

   typedef struct packed {
      logic           scr;
      logic           sdx;
      logic           sdy;
      logic [W-1:0]   adx;
      logic [W-1:0]   ady;
      logic [DRW-1:0] dr;
   } pb_type;

   typedef struct packed {
      logic [NUMW-1:0] axn;
      logic [NUMW-1:0] ayn;
      logic [W-1:0]    adx;
      logic [W-1:0]    ady;
      logic            sxs;
      logic [DRW-1:0]  dr;
   } side_type;

   typedef struct packed {
      logic [NUMW-1:0] axn;
      logic [NUMW-1:0] ayn;
      logic            sxs;
      logic [DRW-1:0]  dr;
   } pc_type;

   localparam int SW = $bits(side_type);

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      mag_of = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // Clamp a quotient magnitude with its sign to the signed coordinate range.
   function automatic logic [W-1:0] sat_of(input logic [W-1:0] q, input logic neg,
                                          input logic ovf);
      logic big;
      big = neg ? (ovf | (q[W-1] & (|q[W-2:0]))) : (ovf | q[W-1]);
      if (big) begin
         sat_of = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         sat_of = neg ? (~q + 1'b1) : q;
      end
   endfunction

   // The pipeline never stalls, so a request is always taken.
   assign busy = 1'b0;

   // ---------------------------------------------------------------- capture
   logic         v0_ff;
   logic [W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [W-2:0] r0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= req_start_x;
      y1_ff <= req_start_y;
      x2_ff <= req_end_x;
      y2_ff <= req_end_y;
      r0_ff <= req_radius;
   end

   // ------------------------------------- differences, magnitudes and signs
   logic signed [W:0] dx_in, dy_in, ndx_in, ndy_in;
   logic              vb_ff;
   logic [W-1:0]      ax1_ff, ay1_ff, ax2_ff, ay2_ff, adx_ff, ady_ff;
   logic              sp1_ff, sp2_ff, sdx_ff, sdy_ff;
   logic [W-2:0]      r_ff;

   assign dx_in  = $signed({x2_ff[W-1], x2_ff}) - $signed({x1_ff[W-1], x1_ff});
   assign dy_in  = $signed({y2_ff[W-1], y2_ff}) - $signed({y1_ff[W-1], y1_ff});
   assign ndx_in = -dx_in;
   assign ndy_in = -dy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      ax1_ff <= mag_of(x1_ff);
      ay1_ff <= mag_of(y1_ff);
      ax2_ff <= mag_of(x2_ff);
      ay2_ff <= mag_of(y2_ff);
      sp1_ff <= x1_ff[W-1] ^ y2_ff[W-1];
      sp2_ff <= y1_ff[W-1] ^ x2_ff[W-1];
      sdx_ff <= dx_in[W];
      sdy_ff <= dy_in[W];
      adx_ff <= dx_in[W] ? ndx_in[W-1:0] : dx_in[W-1:0];
      ady_ff <= dy_in[W] ? ndy_in[W-1:0] : dy_in[W-1:0];
      r_ff   <= r0_ff;
   end

   // ------------------------------------------------ first product stage
   logic [2*W-1:0] p_x1y2, p_y1x2, p_dxdx, p_dydy;
   logic [2*W-3:0] p_rr;

   lci_mul #(.AW(W), .BW(W)) u_mul_x1y2 (
      .clock (clock), .a(ax1_ff), .b(ay2_ff), .p(p_x1y2));
   lci_mul #(.AW(W), .BW(W)) u_mul_y1x2 (
      .clock (clock), .a(ay1_ff), .b(ax2_ff), .p(p_y1x2));
   lci_mul #(.AW(W), .BW(W)) u_mul_dxdx (
      .clock (clock), .a(adx_ff), .b(adx_ff), .p(p_dxdx));
   lci_mul #(.AW(W), .BW(W)) u_mul_dydy (
      .clock (clock), .a(ady_ff), .b(ady_ff), .p(p_dydy));
   lci_mul #(.AW(W-1), .BW(W-1)) u_mul_rr (
      .clock (clock), .a(r_ff), .b(r_ff), .p(p_rr));

   // hold signs and magnitudes level with the multipliers
   pa_type     pa_ff [2];
   logic [1:0] pav_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pav_ff <= '0;
      end else begin
         pav_ff <= {pav_ff[0], vb_ff};
      end
   end

   always_ff @(posedge clock) begin
      pa_ff[0].sp1 <= sp1_ff;
      pa_ff[0].sp2 <= sp2_ff;
      pa_ff[0].sdx <= sdx_ff;
      pa_ff[0].sdy <= sdy_ff;
      pa_ff[0].adx <= adx_ff;
      pa_ff[0].ady <= ady_ff;
      pa_ff[1]     <= pa_ff[0];
   end

   // ---------------------------------------- cross product and squared length
   logic signed [CRW-1:0] t1_in, t2_in;
   logic                  vc_ff;
   logic signed [CRW-1:0] cr_ff;
   logic [DRW-1:0]        dr_c_ff;
   logic [2*W-3:0]        rr_c_ff;
   pa_type                pa_c_ff;

   assign t1_in = pa_ff[1].sp1 ? -$signed({1'b0, p_x1y2}) : $signed({1'b0, p_x1y2});
   assign t2_in = pa_ff[1].sp2 ? -$signed({1'b0, p_y1x2}) : $signed({1'b0, p_y1x2});

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= pav_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      cr_ff   <= t1_in - t2_in;
      dr_c_ff <= DRW'(p_dxdx) + DRW'(p_dydy);
      rr_c_ff <= p_rr;
      pa_c_ff <= pa_ff[1];
   end

   // -------------------------------------------------- magnitude of D
   logic signed [CRW-1:0] ncr_in;
   logic                  vd_ff;
   logic [2*W-1:0]        acr_ff;
   logic                  scr_ff;
   logic [DRW-1:0]        dr_d_ff;
   logic [2*W-3:0]        rr_d_ff;
   pa_type                pa_d_ff;

   assign ncr_in = -cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acr_ff  <= cr_ff[CRW-1] ? ncr_in[2*W-1:0] : cr_ff[2*W-1:0];
      scr_ff  <= cr_ff[CRW-1];
      dr_d_ff <= dr_c_ff;
      rr_d_ff <= rr_c_ff;
      pa_d_ff <= pa_c_ff;
   end

   // ----------------------------------------------- second product stage
   logic [4*W-2:0] p_rrdr;
   logic [4*W-1:0] p_dd;
   logic [3*W-1:0] p_ddy, p_ddx;

   lci_mul #(.AW(2*W-2), .BW(DRW)) u_mul_rrdr (
      .clock (clock), .a(rr_d_ff), .b(dr_d_ff), .p(p_rrdr));
   lci_mul #(.AW(2*W), .BW(2*W)) u_mul_dd (
      .clock (clock), .a(acr_ff), .b(acr_ff), .p(p_dd));
   lci_mul #(.AW(2*W), .BW(W)) u_mul_ddy (
      .clock (clock), .a(acr_ff), .b(pa_d_ff.ady), .p(p_ddy));
   lci_mul #(.AW(2*W), .BW(W)) u_mul_ddx (
      .clock (clock), .a(acr_ff), .b(pa_d_ff.adx), .p(p_ddx));

   pb_type     pb_ff [2];
   logic [1:0] pbv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pbv_ff <= '0;
      end else begin
         pbv_ff <= {pbv_ff[0], vd_ff};
      end
   end

   always_ff @(posedge clock) begin
      pb_ff[0].scr <= scr_ff;
      pb_ff[0].sdx <= pa_d_ff.sdx;
      pb_ff[0].sdy <= pa_d_ff.sdy;
      pb_ff[0].adx <= pa_d_ff.adx;
      pb_ff[0].ady <= pa_d_ff.ady;
      pb_ff[0].dr  <= dr_d_ff;
      pb_ff[1]     <= pb_ff[0];
   end

   // ------------------------------------ discriminant and centre terms
   logic [NUMW-1:0] ddy_ext, ddx_ext;
   logic            ve_ff;
   logic [DETW-1:0] det_ff;
   logic [NUMW-1:0] axn_e_ff, ayn_e_ff;
   logic [W-1:0]    adx_e_ff, ady_e_ff;
   logic            sxs_e_ff;
   logic [DRW-1:0]  dr_e_ff;

   assign ddy_ext = NUMW'(p_ddy);
   assign ddx_ext = NUMW'(p_ddx);

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else begin
         ve_ff <= pbv_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      det_ff   <= {2'b00, p_rrdr} - {1'b0, p_dd};
      // D*dy, and -D*dx with the sign folded in
      axn_e_ff <= (pb_ff[1].scr ^ pb_ff[1].sdy) ? (~ddy_ext + 1'b1) : ddy_ext;
      ayn_e_ff <= (pb_ff[1].scr ^ pb_ff[1].sdx) ? ddx_ext : (~ddx_ext + 1'b1);
      adx_e_ff <= pb_ff[1].adx;
      ady_e_ff <= pb_ff[1].ady;
      sxs_e_ff <= pb_ff[1].sdx ^ pb_ff[1].sdy;
      dr_e_ff  <= pb_ff[1].dr;
   end

   // ------------------------------------------------------- square root
   ctl_type         sq_ctl_in, sq_ctl_out;
   side_type        sq_side_in, sq_side_out;
   logic [SW-1:0]   sq_side_vec;
   logic [SQW-1:0]  sq_root;

   // miss on a negative discriminant or a line of zero length
   assign sq_ctl_in.valid = ve_ff;
   assign sq_ctl_in.hit   = ~det_ff[DETW-1] & (dr_e_ff != '0);

   assign sq_side_in.axn = axn_e_ff;
   assign sq_side_in.ayn = ayn_e_ff;
   assign sq_side_in.adx = adx_e_ff;
   assign sq_side_in.ady = ady_e_ff;
   assign sq_side_in.sxs = sxs_e_ff;
   assign sq_side_in.dr  = dr_e_ff;

   lci_sqrt #(.NW(4*W), .SW(SW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (sq_ctl_in),
      .in_value (det_ff[4*W-1:0]),
      .in_side  (sq_side_in),
      .out_ctl  (sq_ctl_out),
      .out_root (sq_root),
      .out_side (sq_side_vec)
   );

   assign sq_side_out = sq_side_vec;

   // ----------------------------------------------- chord half products
   logic [3*W-1:0] p_dxs, p_dys;

   lci_mul #(.AW(W), .BW(SQW)) u_mul_dxs (
      .clock (clock), .a(sq_side_out.adx), .b(sq_root), .p(p_dxs));
   lci_mul #(.AW(W), .BW(SQW)) u_mul_dys (
      .clock (clock), .a(sq_side_out.ady), .b(sq_root), .p(p_dys));

   pc_type  pc_ff     [2];
   ctl_type pc_ctl_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ctl_ff[0] <= '0;
         pc_ctl_ff[1] <= '0;
      end else begin
         pc_ctl_ff[0] <= sq_ctl_out;
         pc_ctl_ff[1] <= pc_ctl_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      pc_ff[0].axn <= sq_side_out.axn;
      pc_ff[0].ayn <= sq_side_out.ayn;
      pc_ff[0].sxs <= sq_side_out.sxs;
      pc_ff[0].dr  <= sq_side_out.dr;
      pc_ff[1]     <= pc_ff[0];
   end

   // -------------------------------------------------- signed chord terms
   logic [NUMW-1:0] dxs_ext;
   ctl_type         ctl_g_ff;
   logic [NUMW-1:0] sxn_ff, syn_ff, axn_g_ff, ayn_g_ff;
   logic [DRW-1:0]  dr_g_ff;

   assign dxs_ext = NUMW'(p_dxs);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_g_ff <= '0;
      end else begin
         ctl_g_ff <= pc_ctl_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      // sgn(dy)*dx*S, with sgn of zero taken as plus
      sxn_ff   <= pc_ff[1].sxs ? (~dxs_ext + 1'b1) : dxs_ext;
      syn_ff   <= NUMW'(p_dys);
      axn_g_ff <= pc_ff[1].axn;
      ayn_g_ff <= pc_ff[1].ayn;
      dr_g_ff  <= pc_ff[1].dr;
   end

   // ---------------------------------------------------------- numerators
   ctl_type                    ctl_h_ff;
   logic [3:0][NUMW-1:0]       num_ff;
   logic [DRW-1:0]             dr_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_h_ff <= '0;
      end else begin
         ctl_h_ff <= ctl_g_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= axn_g_ff + sxn_ff;
      num_ff[1] <= ayn_g_ff + syn_ff;
      num_ff[2] <= axn_g_ff - sxn_ff;
      num_ff[3] <= ayn_g_ff - syn_ff;
      dr_h_ff   <= dr_g_ff;
   end

   // ------------------------------------------------------------ division
   ctl_type               dv_ctl;
   logic [3:0][W-1:0]     dv_quot;
   logic [3:0]            dv_neg, dv_ovf;

   lci_div #(.NW(NUMW), .DW(DRW), .QW(W), .LANES(4)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ctl_h_ff),
      .in_num   (num_ff),
      .in_den   (dr_h_ff),
      .out_ctl  (dv_ctl),
      .out_quot (dv_quot),
      .out_neg  (dv_neg),
      .out_ovf  (dv_ovf)
   );

   // ------------------------------------------------ saturate and present
   logic         strobe_ff, hit_ff;
   logic [W-1:0] fx_ff, fy_ff, sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_ctl.valid;
      end
   end

   // drop the coordinates to zero on a miss
   always_ff @(posedge clock) begin
      hit_ff <= dv_ctl.hit;
      fx_ff  <= dv_ctl.hit ? sat_of(dv_quot[0], dv_neg[0], dv_ovf[0]) : '0;
      fy_ff  <= dv_ctl.hit ? sat_of(dv_quot[1], dv_neg[1], dv_ovf[1]) : '0;
      sx_ff  <= dv_ctl.hit ? sat_of(dv_quot[2], dv_neg[2], dv_ovf[2]) : '0;
      sy_ff  <= dv_ctl.hit ? sat_of(dv_quot[3], dv_neg[3], dv_ovf[3]) : '0;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_first_x  = fx_ff;
   assign rsp_first_y  = fy_ff;
   assign rsp_second_x = sx_ff;
   assign rsp_second_y = sy_ff;

endmodule

// ===== tb/sv/tb_line_circle_intersection.sv =====
// Self-checking testbench for the line and circle intersection core.
`timescale 1ns / 1ps

// Scoreboard: predicts the intersection of each accepted request and checks results.
class lci_scoreboard;
   typedef struct {
      logic              hit;
      logic signed [31:0] fx, fy, sx, sy;
   } isect_type;

   isect_type expected_q[$];
   int        errors;
   int        hits;
   int        checked;

   function logic signed [255:0] clamp_coord(logic signed [255:0] v);
      logic signed [255:0] hi, lo;
      hi = 256'sd2147483647;
      lo = -256'sd2147483648;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Truncating division on magnitudes.
   function logic signed [255:0] div_trunc(logic signed [255:0] n, logic signed [255:0] d);
      logic [255:0] an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q  = an / ad;
      return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
   endfunction

   function logic [255:0] floor_root(logic [255:0] n);
      logic [255:0] r, c;
      r = '0;
      for (int k = 127; k >= 0; k--) begin
         c = r | (256'd1 << k);
         if (c * c <= n) r = c;
      end
      return r;
   endfunction

   function void note_request(logic signed [31:0] x1, logic signed [31:0] y1,
                              logic signed [31:0] x2, logic signed [31:0] y2,
                              logic [30:0] rad);
      logic signed [255:0] wx1, wy1, wx2, wy2, wr, dx, dy, dr, cr, det, s, ex, ey, ax, ay;
      isect_type e;
      wx1 = 256'(x1); wy1 = 256'(y1); wx2 = 256'(x2); wy2 = 256'(y2);
      wr  = $signed({225'd0, rad});
      dx  = wx2 - wx1;
      dy  = wy2 - wy1;
      dr  = dx * dx + dy * dy;
      cr  = wx1 * wy2 - wy1 * wx2;
      det = wr * wr * dr - cr * cr;
      e = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
      if (det >= 0 && dr != 0) begin
         s  = $signed(floor_root(det));
         ex = dx * s;
         if (dy < 0) ex = -ex;
         ey = (dy < 0 ? -dy : dy) * s;
         ax = cr * dy;
         ay = -(cr * dx);
         e.hit = 1'b1;
         e.fx = 32'(clamp_coord(div_trunc(ax + ex, dr)));
         e.fy = 32'(clamp_coord(div_trunc(ay + ey, dr)));
         e.sx = 32'(clamp_coord(div_trunc(ax - ex, dr)));
         e.sy = 32'(clamp_coord(div_trunc(ay - ey, dr)));
      end
      expected_q.push_back(e);
   endfunction

   function void check_result(logic h, logic signed [31:0] fx, logic signed [31:0] fy,
                              logic signed [31:0] sx, logic signed [31:0] sy);
      isect_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result hit=%0b", $time, h);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      checked++;
      if (h) hits++;
      if (h !== e.hit) begin
         $display("%0t: hit expected %0b actual %0b", $time, e.hit, h); errors++;
      end
      if (fx !== e.fx) begin
         $display("%0t: first_x expected %0d actual %0d", $time, e.fx, fx); errors++;
      end
      if (fy !== e.fy) begin
         $display("%0t: first_y expected %0d actual %0d", $time, e.fy, fy); errors++;
      end
      if (sx !== e.sx) begin
         $display("%0t: second_x expected %0d actual %0d", $time, e.sx, sx); errors++;
      end
      if (sy !== e.sy) begin
         $display("%0t: second_y expected %0d actual %0d", $time, e.sy, sy); errors++;
      end
   endfunction
endclass

module tb_line_circle_intersection;
   localparam int LATENCY = 111;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic        [30:0] req_radius;
   logic               rsp_strobe, rsp_hit;
   logic signed [31:0] rsp_first_x, rsp_first_y, rsp_second_x, rsp_second_y;

   lci_scoreboard isect_board;
   int            idle_pct;
   int            sent;

   line_circle_intersection u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_end_x    (req_end_x),
      .req_end_y    (req_end_y),
      .req_radius   (req_radius),
      .rsp_strobe   (rsp_strobe),
      .rsp_hit      (rsp_hit),
      .rsp_first_x  (rsp_first_x),
      .rsp_first_y  (rsp_first_y),
      .rsp_second_x (rsp_second_x),
      .rsp_second_y (rsp_second_y)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #20ms;
      $display("line_circle_intersection verification failed");
      $finish;
   end

   // Check every strobed result at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         isect_board.check_result(rsp_hit, rsp_first_x, rsp_first_y,
                                  rsp_second_x, rsp_second_y);
   end

   // Present one request, hold it until accepted, then note it; idle gaps are random.
   task automatic send_request(logic signed [31:0] x1, logic signed [31:0] y1,
                               logic signed [31:0] x2, logic signed [31:0] y2,
                               logic [30:0] rad);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_start_x <= x1;
      req_start_y <= y1;
      req_end_x   <= x2;
      req_end_y   <= y2;
      req_radius  <= rad;
      @(posedge clock);
      while (busy) @(posedge clock);
      isect_board.note_request(x1, y1, x2, y2, rad);
      sent++;
   endtask

   // Drop start and hold until every outstanding request has returned.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (isect_board.expected_q.size() != 0) @(posedge clock);
   endtask

   // Random coordinate: mostly small magnitudes so that lines cross the circle often.
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $signed($urandom());
         1: return $signed($urandom_range(2 * 65536 * 50)) - 65536 * 50;
         default: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
      endcase
   endfunction

   function automatic logic [30:0] rand_radius();
      case ($urandom_range(3))
         0: return 31'($urandom());
         1: return 31'($urandom_range(65536 * 60));
         default: return 31'($urandom_range(65536 * 6));
      endcase
   endfunction

   // Random request; a share are crafted as tangents, degenerate lines or vertical lines.
   task automatic send_random();
      logic signed [31:0] x1, y1, x2, y2;
      logic        [30:0] rad;
      x1 = rand_coord(); y1 = rand_coord(); x2 = rand_coord(); y2 = rand_coord();
      rad = rand_radius();
      case ($urandom_range(9))
         0: begin x2 = x1; y2 = y1; end
         1: begin
            // horizontal line at y = r touches the circle
            y1 = $signed({1'b0, rad}); y2 = y1;
         end
         2: begin x2 = x1; end
         default: ;
      endcase
      send_request(x1, y1, x2, y2, rad);
   endtask

   initial begin
      isect_board = new();
      idle_pct    = 37;
      sent        = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_start_x = '0; req_start_y = '0; req_end_x = '0; req_end_y = '0; req_radius = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: chord through centre, tangent, miss, degenerate, extremes.
      send_request(-32'sd131072, 32'sd0, 32'sd131072, 32'sd0, 31'd65536);
      send_request(32'sd0, -32'sd131072, 32'sd0, 32'sd131072, 31'd65536);
      send_request(-32'sd131072, 32'sd65536, 32'sd131072, 32'sd65536, 31'd65536);
      send_request(-32'sd131072, 32'sd131072, 32'sd131072, 32'sd131072, 31'd65536);
      send_request(32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, 31'd131072);
      send_request(32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
      send_request(32'sd131072, 32'sd131072, -32'sd131072, -32'sd131072, 31'd65536);
      send_request(32'sd131072, -32'sd131072, -32'sd131072, 32'sd131072, 31'd65536);
      send_request(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
      send_request(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
      send_request(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 31'h7fffffff);
      send_request(32'sd0, 32'sd0, 32'sd1, 32'sd0, 31'h7fffffff);
      send_request(32'sd0, 32'sd0, 32'sd1, 32'sd1, 31'h7fffffff);
      send_request(32'hffffffff, 32'hffffffff, 32'sd0, 32'sd0, 31'd0);
      send_request(32'sd0, 32'sd1, 32'sd1, 32'sd1, 31'd1);
      send_request(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 31'h2aaaaaaa);
      send_request(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 31'h55555555);

      // Pause until the pipeline is empty before the random phases.
      drain_pipeline();

      for (int i = 0; i < 470; i++) send_random();
      idle_pct = 69;
      for (int i = 0; i < 460; i++) send_random();
      idle_pct = 0;
      for (int i = 0; i < 460; i++) send_random();

      drain_pipeline();
      repeat (LATENCY + 20) @(posedge clock);

      $display("Sent %0d requests; %0d results checked, %0d of them hits.",
               sent, isect_board.checked, isect_board.hits);
      $display("Covered directed extremes, tangents, misses and degenerate lines under idle mixes.");
      if (isect_board.errors == 0 && isect_board.expected_q.size() == 0)
         $display("line_circle_intersection verification clean");
      else
         $display("line_circle_intersection verification failed");
      $finish;
   end
endmodule
